// ===== hdl/tmc_pkg.sv =====
package tmc_pkg;

	// Default number of samples averaged into one block.
	localparam int AVG_SAMPLES_DEF = 10;

	// Event kinds.
	localparam logic [1:0] FUNC_POLL   = 2'd0;
	localparam logic [1:0] FUNC_SAMPLE = 2'd1;
	localparam logic [1:0] FUNC_TICK   = 2'd2;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_BAND   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT_STEP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT_MIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT_MAX  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_EXIT_TICKS    = 3'd4;

	// Register reset values.
	localparam logic [4:0] SWITCH_BAND_RST   = 5'd5;
	localparam logic [3:0] SETPOINT_STEP_RST = 4'd5;
	localparam logic [6:0] SETPOINT_MIN_RST  = 7'd35;
	localparam logic [6:0] SETPOINT_MAX_RST  = 7'd75;
	localparam logic [7:0] EXIT_TICKS_RST    = 8'd5;
	localparam logic [6:0] SETPOINT_RST      = 7'd45;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] sample;
		logic       up_pressed;
		logic       down_pressed;
	} evt_t;

	typedef struct packed {
		logic       heater_on;
		logic       cooler_on;
		logic       heater_lamp;
		logic       setting_mode;
		logic [6:0] setpoint_now;
		logic       setpoint_saved;
		logic       display_write;
		logic [4:0] display_tens;
		logic [3:0] display_ones;
		logic [7:0] average_temp;
	} res_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [7:0]           value;
	} cfg_wr_t;

	typedef struct packed {
		logic [4:0] switch_band;
		logic [3:0] setpoint_step;
		logic [6:0] setpoint_min;
		logic [6:0] setpoint_max;
		logic [7:0] exit_ticks;
	} cfg_t;

	typedef struct packed {
		logic [4:0] tens;
		logic [3:0] ones;
	} digits_t;

	// Splits a value below 256 into decimal digits. The quotient by ten comes
	// from a multiplication by 205/2048, which is exact over this range.
	function automatic digits_t split_digits(logic [7:0] v);
		logic [15:0] prod;
		logic [7:0]  rem;
		digits_t     d;
		prod   = 16'(v) * 16'd205;
		d.tens = prod[15:11];
		rem    = v - 8'({d.tens, 3'b000}) - 8'({d.tens, 1'b0});
		d.ones = rem[3:0];
		return d;
	endfunction

endpackage

// ===== hdl/tmc_stream_if.sv =====
interface tmc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/tmc_core.sv =====
module tmc_core #(
	parameter int AVG_SAMPLES = tmc_pkg::AVG_SAMPLES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  tmc_pkg::evt_t evt_s1,
	input  tmc_pkg::cfg_t cfg,
	output tmc_pkg::res_t res_next
);

	localparam int SUM_W    = $clog2(255 * AVG_SAMPLES + 1);
	localparam int CNT_W    = $clog2(AVG_SAMPLES + 1);
	localparam int RECIP_SH = SUM_W + 8;
	localparam int PROD_W   = SUM_W + RECIP_SH + 1;
	// Rounded-up reciprocal of the block length; exact for every block sum.
	localparam logic [RECIP_SH:0] AVG_RECIP =
		(RECIP_SH + 1)'((2 ** RECIP_SH + AVG_SAMPLES - 1) / AVG_SAMPLES);

	logic             mode_q, heat_q, cool_q, led_q;
	logic             blink_run_q, led_arm_q, disp_arm_q;
	logic             led_blink_q, disp_blink_q, wait_rel_q;
	logic             force_show_q, digits_phase_q;
	logic [7:0]       idle_cnt_q, prev_smp_q, avg_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [6:0]       setpoint_q;

	logic             mode_n, heat_n, cool_n, led_n;
	logic             blink_run_n, led_arm_n, disp_arm_n;
	logic             led_blink_n, disp_blink_n, wait_rel_n;
	logic             force_show_n, digits_phase_n;
	logic [7:0]       idle_cnt_n, prev_smp_n, avg_n;
	logic [SUM_W-1:0] sum_n, sum_add;
	logic [CNT_W-1:0] cnt_n, cnt_inc;
	logic [6:0]       setpoint_n;

	logic             saved, dwrite;
	tmc_pkg::digits_t digits, smp_digits, sp_digits;
	logic             pressed, heat_cond, cool_cond;
	logic [7:0]       sp_up, sp_floor;
	logic [PROD_W-1:0] avg_prod;

	assign pressed    = evt_s1.up_pressed | evt_s1.down_pressed;
	assign heat_cond  = ({1'b0, avg_q} + 9'(cfg.switch_band)) <= 9'(setpoint_q);
	assign cool_cond  = (8'(setpoint_q) + 8'(cfg.switch_band)) <= avg_q;
	assign sp_up      = 8'(setpoint_q) + 8'(cfg.setpoint_step);
	assign sp_floor   = 8'(cfg.setpoint_min) + 8'(cfg.setpoint_step);
	assign sum_add    = sum_q + SUM_W'(evt_s1.sample);
	assign cnt_inc    = cnt_q + 1'b1;
	assign avg_prod   = PROD_W'(sum_add) * PROD_W'(AVG_RECIP);
	assign smp_digits = tmc_pkg::split_digits(evt_s1.sample);
	assign sp_digits  = tmc_pkg::split_digits(8'(setpoint_q));

	always_comb begin
		mode_n         = mode_q;
		heat_n         = heat_q;
		cool_n         = cool_q;
		led_n          = led_q;
		blink_run_n    = blink_run_q;
		led_arm_n      = led_arm_q;
		disp_arm_n     = disp_arm_q;
		led_blink_n    = led_blink_q;
		disp_blink_n   = disp_blink_q;
		wait_rel_n     = wait_rel_q;
		force_show_n   = force_show_q;
		digits_phase_n = digits_phase_q;
		idle_cnt_n     = idle_cnt_q;
		prev_smp_n     = prev_smp_q;
		avg_n          = avg_q;
		sum_n          = sum_q;
		cnt_n          = cnt_q;
		setpoint_n     = setpoint_q;
		saved          = 1'b0;
		dwrite         = 1'b0;
		digits         = '0;

		case (evt_s1.func)
			tmc_pkg::FUNC_POLL: begin
				if (!mode_q) begin
					if (heat_cond) begin
						heat_n = 1'b1;
						cool_n = 1'b0;
						if (led_arm_q) begin
							blink_run_n = 1'b1;
							led_arm_n   = 1'b0;
							led_blink_n = 1'b1;
						end
					end else begin
						blink_run_n = 1'b0;
						led_blink_n = 1'b0;
						led_arm_n   = 1'b1;
						heat_n      = 1'b0;
						cool_n      = cool_cond;
						led_n       = cool_cond;
					end
					// Any press leaves run mode; the setting mode waits for release first.
					if (pressed) begin
						blink_run_n = 1'b0;
						led_blink_n = 1'b0;
						led_arm_n   = 1'b1;
						led_n       = 1'b0;
						mode_n      = 1'b1;
						disp_arm_n  = 1'b1;
						wait_rel_n  = 1'b1;
					end
				end else begin
					if (disp_arm_q) begin
						blink_run_n  = 1'b1;
						disp_blink_n = 1'b1;
						disp_arm_n   = 1'b0;
					end
					if (!(wait_rel_q && pressed)) begin
						wait_rel_n = 1'b0;
						if (evt_s1.up_pressed && (setpoint_q < cfg.setpoint_max)) begin
							setpoint_n = (sp_up > 8'(cfg.setpoint_max)) ?
								cfg.setpoint_max : sp_up[6:0];
							saved      = 1'b1;
							wait_rel_n = 1'b1;
							idle_cnt_n = '0;
						end else if (evt_s1.down_pressed &&
								(setpoint_q > cfg.setpoint_min)) begin
							setpoint_n = (8'(setpoint_q) >= sp_floor) ?
								(setpoint_q - 7'(cfg.setpoint_step)) : cfg.setpoint_min;
							saved      = 1'b1;
							wait_rel_n = 1'b1;
							idle_cnt_n = '0;
						end else if (!pressed && (idle_cnt_q == cfg.exit_ticks)) begin
							blink_run_n  = 1'b0;
							mode_n       = 1'b0;
							disp_blink_n = 1'b0;
							idle_cnt_n   = '0;
							force_show_n = 1'b1;
						end
					end
				end
			end
			tmc_pkg::FUNC_SAMPLE: begin
				if (((evt_s1.sample != prev_smp_q) && !mode_q) || force_show_q) begin
					dwrite       = 1'b1;
					digits       = smp_digits;
					force_show_n = 1'b0;
				end
				prev_smp_n = evt_s1.sample;
				if (cnt_inc == CNT_W'(AVG_SAMPLES)) begin
					avg_n = avg_prod[RECIP_SH +: 8];
					cnt_n = '0;
					sum_n = '0;
				end else begin
					cnt_n = cnt_inc;
					sum_n = sum_add;
				end
			end
			tmc_pkg::FUNC_TICK: begin
				if (blink_run_q) begin
					idle_cnt_n = idle_cnt_q + 8'd1;
					if (led_blink_q) begin
						led_n = !led_q;
					end else if (disp_blink_q) begin
						// Alternate between showing the setpoint and a blank write.
						dwrite = 1'b1;
						if (digits_phase_q) begin
							digits         = sp_digits;
							digits_phase_n = 1'b0;
						end else begin
							digits_phase_n = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase

		res_next.heater_on      = heat_n;
		res_next.cooler_on      = cool_n;
		res_next.heater_lamp    = led_n;
		res_next.setting_mode   = mode_n;
		res_next.setpoint_now   = setpoint_n;
		res_next.setpoint_saved = saved;
		res_next.display_write  = dwrite;
		res_next.display_tens   = digits.tens;
		res_next.display_ones   = digits.ones;
		res_next.average_temp   = avg_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= 1'b0;
			heat_q         <= 1'b0;
			cool_q         <= 1'b0;
			led_q          <= 1'b0;
			blink_run_q    <= 1'b0;
			led_arm_q      <= 1'b1;
			disp_arm_q     <= 1'b0;
			led_blink_q    <= 1'b0;
			disp_blink_q   <= 1'b0;
			wait_rel_q     <= 1'b0;
			force_show_q   <= 1'b0;
			digits_phase_q <= 1'b1;
			idle_cnt_q     <= '0;
			prev_smp_q     <= '0;
			avg_q          <= '0;
			sum_q          <= '0;
			cnt_q          <= '0;
			setpoint_q     <= tmc_pkg::SETPOINT_RST;
		end else if (step) begin
			mode_q         <= mode_n;
			heat_q         <= heat_n;
			cool_q         <= cool_n;
			led_q          <= led_n;
			blink_run_q    <= blink_run_n;
			led_arm_q      <= led_arm_n;
			disp_arm_q     <= disp_arm_n;
			led_blink_q    <= led_blink_n;
			disp_blink_q   <= disp_blink_n;
			wait_rel_q     <= wait_rel_n;
			force_show_q   <= force_show_n;
			digits_phase_q <= digits_phase_n;
			idle_cnt_q     <= idle_cnt_n;
			prev_smp_q     <= prev_smp_n;
			avg_q          <= avg_n;
			sum_q          <= sum_n;
			cnt_q          <= cnt_n;
			setpoint_q     <= setpoint_n;
		end
	end

endmodule

// ===== hdl/thermostat_mode_controller.sv =====
// Thermostat mode controller: every event transaction on evt (button poll, temperature
// sample or blink tick) yields exactly one result transaction on res, carrying the drive
// levels, mode, setpoint, display strobe and digits, and the latest block average of
// AVG_SAMPLES samples. Events are taken one per clock cycle unless res stalls them; each
// event passes through the input register, a single pass of next-state logic and the
// result register before its result is valid on res. Back pressure on res stalls evt
// only once both registers hold an item. Configuration writes on cfg are always accepted
// and should be issued only while no event is in flight.
module thermostat_mode_controller #(
	parameter int AVG_SAMPLES = tmc_pkg::AVG_SAMPLES_DEF
) (
	input logic         clk,
	input logic         arst_n,
	tmc_stream_if.sink   evt,
	tmc_stream_if.source res,
	tmc_stream_if.sink   cfg
);

	tmc_pkg::evt_t evt_s1;
	logic          valid_s1;
	tmc_pkg::res_t res_q;
	logic          res_valid_q;
	tmc_pkg::res_t res_next;
	tmc_pkg::cfg_t cfg_q;
	tmc_pkg::cfg_wr_t cfg_wr;
	logic          out_free;
	logic          adv;

	assign out_free  = !res_valid_q || res.ready;
	assign adv       = valid_s1 && out_free;
	assign evt.ready = !valid_s1 || out_free;
	assign res.valid = res_valid_q;
	assign res.data  = res_q;
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (evt.ready) begin
				valid_s1 <= evt.valid;
			end
			if (out_free) begin
				res_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			evt_s1 <= evt.data;
		end
		if (adv) begin
			res_q <= res_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.switch_band   <= tmc_pkg::SWITCH_BAND_RST;
			cfg_q.setpoint_step <= tmc_pkg::SETPOINT_STEP_RST;
			cfg_q.setpoint_min  <= tmc_pkg::SETPOINT_MIN_RST;
			cfg_q.setpoint_max  <= tmc_pkg::SETPOINT_MAX_RST;
			cfg_q.exit_ticks    <= tmc_pkg::EXIT_TICKS_RST;
		end else if (cfg.valid) begin
			case (cfg_wr.index)
				tmc_pkg::CFG_SWITCH_BAND:   cfg_q.switch_band   <= cfg_wr.value[4:0];
				tmc_pkg::CFG_SETPOINT_STEP: cfg_q.setpoint_step <= cfg_wr.value[3:0];
				tmc_pkg::CFG_SETPOINT_MIN:  cfg_q.setpoint_min  <= cfg_wr.value[6:0];
				tmc_pkg::CFG_SETPOINT_MAX:  cfg_q.setpoint_max  <= cfg_wr.value[6:0];
				tmc_pkg::CFG_EXIT_TICKS:    cfg_q.exit_ticks    <= cfg_wr.value;
				default: begin
				end
			endcase
		end
	end

	tmc_core #(
		.AVG_SAMPLES(AVG_SAMPLES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.evt_s1  (evt_s1),
		.cfg     (cfg_q),
		.res_next(res_next)
	);

endmodule
